[src/rfd_pkg.sv]
// Shared types, constants and codes for the record field deframer.
`default_nettype none
package rfd_pkg;

    // Fixed field widths.
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default width of the length prefix accumulator.
    localparam int LEN_BITS_DEF = 16;

    // Framing mode codes.
    localparam logic [1:0] MODE_FIXED  = 2'd0;
    localparam logic [1:0] MODE_DELIM  = 2'd1;
    localparam logic [1:0] MODE_LENGTH = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [1:0]         MODE_RESET  = MODE_FIXED;
    localparam logic [COUNT_W-1:0] WIDTH_RESET = 16'd1;
    localparam logic [BYTE_W-1:0]  DELIM_RESET = 8'd124;

    // Character codes.
    localparam logic [BYTE_W-1:0] CHR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NINE  = 8'h39;

    // One input byte with its end-of-buffer mark.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              buffer_end;
    } item_t;

    // One result.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              field_done;
    } res_t;

endpackage
`default_nettype wire

[src/record_field_deframer.sv]
// Top level of the record field deframer.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     data_byte, buffer_end
//   out      output     out_valid / out_ready   out_byte, byte_valid, field_done
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte is accepted per cycle when the output side keeps up; a byte's
// result is presented after its input transfer through the input register and
// the result register. The rate is set by the combinational framing logic
// between them, which also updates the field state.
// A stall on the output holds the result register and the input register.
// Reset clears the field state and loads the register reset values.
`default_nettype none
module record_field_deframer #(
    parameter int LEN_BITS = rfd_pkg::LEN_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            buffer_end,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [7:0]                           out_byte,
    output logic                                 byte_valid,
    output logic                                 field_done,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rfd_pkg::item_t item;
    rfd_pkg::res_t  res;
    logic           item_valid;
    logic           take;
    logic           out_free;
    logic           res_valid;

    rfd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    rfd_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res        (res),
        .res_valid  (res_valid)
    );

    rfd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_valid),
        .res        (res),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .field_done (field_done)
    );

`ifndef SYNTH
    // Every result carries a byte, ends a field, or both.
    a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid || field_done))
        else $error("result with neither a byte nor a field end");

    // A result without a field byte carries a zero byte.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (out_byte == 8'h00))
        else $error("nonzero byte in a result without a field byte");

    // With the result register empty the input side never stalls.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while the result register is empty");

    // A result is loaded only when a held item is processed.
    a_load_take: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (take && item_valid))
        else $error("result loaded without a processed item");
`endif

endmodule
`default_nettype wire

[src/rfd_in_reg.sv]
// Input register stage of the record field deframer.
`default_nettype none
module rfd_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          buffer_end,
    input  wire logic          take,
    output rfd_pkg::item_t     item,
    output logic               item_valid
);

    logic           valid_reg;
    logic           valid_next;
    rfd_pkg::item_t item_reg;

    // The stage can load whenever it is empty or its item is consumed this cycle.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload is captured on each input transfer.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.data_byte  <= data_byte;
            item_reg.buffer_end <= buffer_end;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule
`default_nettype wire

[src/rfd_core.sv]
// Configuration registers, field state and framing logic of the deframer.
`default_nettype none
module rfd_core #(
    parameter int LEN_BITS = rfd_pkg::LEN_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            item_valid,
    input  wire rfd_pkg::item_t                  item,
    input  wire logic                            out_free,
    output logic                                 take,
    output rfd_pkg::res_t                        res,
    output logic                                 res_valid
);

    localparam int ACC_W = LEN_BITS + 4;

    // Configuration registers.
    logic [1:0]                     mode_reg;
    logic [rfd_pkg::COUNT_W-1:0]    width_reg;
    logic [rfd_pkg::BYTE_W-1:0]     delim_reg;

    // Field state.
    logic [rfd_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [LEN_BITS-1:0]            acc_reg, acc_next;
    logic                           payload_reg, payload_next;
    logic                           digit_reg, digit_next;

    logic                           cfg_xfer;
    logic                           mode_write;
    logic [rfd_pkg::COUNT_W-1:0]    count_inc;
    logic [rfd_pkg::COUNT_W-1:0]    width_eff;
    logic [LEN_BITS-1:0]            acc_dec;
    logic [LEN_BITS-1:0]            acc_sat;
    logic [ACC_W-1:0]               acc_x10;
    logic [3:0]                     digit_val;
    logic                           is_digit;
    logic                           r_valid;
    logic                           r_done;
    logic [rfd_pkg::BYTE_W-1:0]     b;
    logic                           last;

    assign cfg_ready  = 1'b1;
    assign cfg_xfer   = cfg_valid && cfg_ready;
    assign mode_write = cfg_xfer && (cfg_index == rfd_pkg::CFG_MODE);

    // An item is processed when the result register can take its outcome.
    assign take = item_valid && out_free;

    assign b    = item.data_byte;
    assign last = item.buffer_end;

    // Arithmetic shared by the mode decoder.
    assign count_inc = count_reg + rfd_pkg::COUNT_W'(1);
    assign width_eff = (width_reg == '0) ? rfd_pkg::COUNT_W'(1) : width_reg;
    assign acc_dec   = acc_reg - LEN_BITS'(1);
    assign is_digit  = (b >= rfd_pkg::CHR_ZERO) && (b <= rfd_pkg::CHR_NINE);
    assign digit_val = 4'(b - rfd_pkg::CHR_ZERO);
    assign acc_x10   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                       + ACC_W'(digit_val);
    // Saturate the prefix value at its largest representable length.
    assign acc_sat   = (acc_x10[ACC_W-1:LEN_BITS] != '0) ? '1 : acc_x10[LEN_BITS-1:0];

    // Framing decoder: next field state and the result of this byte.
    always_comb
    begin
        count_next   = count_reg;
        acc_next     = acc_reg;
        payload_next = payload_reg;
        digit_next   = digit_reg;
        r_valid      = 1'b0;
        r_done       = 1'b0;
        unique case (mode_reg)
            rfd_pkg::MODE_FIXED:
            begin
                r_valid = (b != rfd_pkg::CHR_NUL);
                r_done  = last || (count_inc >= width_eff);
                count_next = r_done ? '0 : count_inc;
            end
            rfd_pkg::MODE_DELIM:
            begin
                if (b == delim_reg)
                begin
                    r_done = 1'b1;
                end
                else
                begin
                    r_valid = 1'b1;
                    r_done  = last;
                end
            end
            rfd_pkg::MODE_LENGTH:
            begin
                if (payload_reg)
                begin
                    r_valid = 1'b1;
                    r_done  = last || (acc_dec == '0);
                    if (r_done)
                    begin
                        count_next   = '0;
                        acc_next     = '0;
                        payload_next = 1'b0;
                        digit_next   = 1'b0;
                    end
                    else
                    begin
                        acc_next = acc_dec;
                    end
                end
                else if (b == rfd_pkg::CHR_SPACE)
                begin
                    // An empty or zero prefix, or a space at buffer end, ends an empty field.
                    if (last || !digit_reg || (acc_reg == '0))
                    begin
                        r_done       = 1'b1;
                        count_next   = '0;
                        acc_next     = '0;
                        payload_next = 1'b0;
                        digit_next   = 1'b0;
                    end
                    else
                    begin
                        payload_next = 1'b1;
                    end
                end
                else
                begin
                    if (is_digit)
                    begin
                        acc_next   = acc_sat;
                        digit_next = 1'b1;
                    end
                    // Buffer end inside a prefix ends an empty field.
                    if (last)
                    begin
                        r_done       = 1'b1;
                        count_next   = '0;
                        acc_next     = '0;
                        payload_next = 1'b0;
                        digit_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                // The unused mode consumes the byte without a result.
                r_valid = 1'b0;
            end
        endcase
    end

    assign res.out_byte   = r_valid ? b : '0;
    assign res.byte_valid = r_valid;
    assign res.field_done = r_done;
    assign res_valid      = take && (r_valid || r_done);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= rfd_pkg::MODE_RESET;
            width_reg <= rfd_pkg::WIDTH_RESET;
            delim_reg <= rfd_pkg::DELIM_RESET;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                rfd_pkg::CFG_MODE:  mode_reg  <= cfg_data[1:0];
                rfd_pkg::CFG_WIDTH: width_reg <= cfg_data;
                rfd_pkg::CFG_DELIM: delim_reg <= cfg_data[rfd_pkg::BYTE_W-1:0];
                default:            mode_reg  <= mode_reg;
            endcase
        end
    end

    // Field state; a mode write returns it to the start of a field.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            acc_reg     <= '0;
            payload_reg <= 1'b0;
            digit_reg   <= 1'b0;
        end
        else if (mode_write)
        begin
            count_reg   <= '0;
            acc_reg     <= '0;
            payload_reg <= 1'b0;
            digit_reg   <= 1'b0;
        end
        else if (take)
        begin
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            payload_reg <= payload_next;
            digit_reg   <= digit_next;
        end
    end

endmodule
`default_nettype wire

[src/rfd_out_reg.sv]
// Result register stage of the record field deframer.
`default_nettype none
module rfd_out_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire rfd_pkg::res_t  res,
    output logic                out_free,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                field_done
);

    logic          valid_reg;
    logic          valid_next;
    rfd_pkg::res_t res_reg;

    // The register can take a new result when empty or being drained.
    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = res_reg.out_byte;
    assign byte_valid = res_reg.byte_valid;
    assign field_done = res_reg.field_done;

endmodule
`default_nettype wire

[bench/rfd_check_pkg.sv]
// Scoreboard class that predicts and checks the results of the record field deframer.
package rfd_check_pkg;

    import rfd_pkg::*;

    // Mode code that selects no framing, and a register index with no register behind it.
    localparam logic [1:0]           MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    // Largest value of the length prefix accumulator.
    localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS_DEF) - 1;

    class deframe_scoreboard;

        // Copy of the configuration registers.
        logic [1:0]              mode;
        logic [COUNT_W-1:0]      width;
        logic [BYTE_W-1:0]       delim;

        // Copy of the field state.
        logic [COUNT_W-1:0]      fixed_count;
        logic [LEN_BITS_DEF-1:0] length_left;
        bit                      in_payload;
        bit                      digit_seen;

        // Results still owed by the block, oldest first.
        res_t                    owed_results[$];
        int unsigned             errors;

        function new();
            mode   = MODE_RESET;
            width  = WIDTH_RESET;
            delim  = DELIM_RESET;
            errors = 0;
            clear_field();
        endfunction

        function void clear_field();
            fixed_count = '0;
            length_left = '0;
            in_payload  = 0;
            digit_seen  = 0;
        endfunction

        // Track a register write; a mode write restarts the field.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE:
                begin
                    mode = data[1:0];
                    clear_field();
                end
                CFG_WIDTH: width = data;
                CFG_DELIM: delim = data[BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out what one accepted byte produces and queue it.
        function void note_input(logic [BYTE_W-1:0] b, logic last);
            res_t               r;
            logic [COUNT_W-1:0] w;
            longint unsigned    v;
            bit                 has;
            bit                 done;
            r   = '0;
            has = 0;
            case (mode)
                MODE_FIXED:
                begin
                    // A width of zero behaves as a width of one.
                    w = (width == '0) ? COUNT_W'(1) : width;
                    fixed_count = fixed_count + 1'b1;
                    done = last || (fixed_count >= w);
                    if (done)
                        fixed_count = '0;
                    r.byte_valid = (b != CHR_NUL);
                    r.out_byte   = r.byte_valid ? b : '0;
                    r.field_done = done;
                    has = r.byte_valid || done;
                end
                MODE_DELIM:
                begin
                    // The delimiter itself is dropped and only closes the field.
                    if (b == delim)
                        r.field_done = 1'b1;
                    else
                    begin
                        r.out_byte   = b;
                        r.byte_valid = 1'b1;
                        r.field_done = last;
                    end
                    has = 1;
                end
                MODE_LENGTH:
                begin
                    if (in_payload)
                    begin
                        length_left = length_left - 1'b1;
                        done = last || (length_left == '0);
                        if (done)
                            clear_field();
                        r.out_byte   = b;
                        r.byte_valid = 1'b1;
                        r.field_done = done;
                        has = 1;
                    end
                    else if (b == CHR_SPACE)
                    begin
                        // An empty or zero prefix, or a space at buffer end, gives an empty field.
                        if (last || !digit_seen || length_left == '0)
                        begin
                            clear_field();
                            r.field_done = 1'b1;
                            has = 1;
                        end
                        else
                            in_payload = 1;
                    end
                    else
                    begin
                        if (b >= CHR_ZERO && b <= CHR_NINE)
                        begin
                            v = length_left;
                            v = v * 10 + (b - CHR_ZERO);
                            length_left = (v > LEN_MAX) ? LEN_MAX[LEN_BITS_DEF-1:0]
                                                        : v[LEN_BITS_DEF-1:0];
                            digit_seen = 1;
                        end
                        // Buffer end inside the prefix closes an empty field.
                        if (last)
                        begin
                            clear_field();
                            r.field_done = 1'b1;
                            has = 1;
                        end
                    end
                end
                default: ;
            endcase
            if (has)
                owed_results = {owed_results, r};
        endfunction

        // Compare one result transfer with the oldest owed result.
        function void check_result(logic [BYTE_W-1:0] ob, logic bv, logic fd);
            res_t e;
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: out_byte %0h byte_valid %0b field_done %0b",
                       ob, bv, fd);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            if (ob !== e.out_byte)
            begin
                $error("out_byte mismatch: expected %0h, actual %0h", e.out_byte, ob);
                errors++;
            end
            if (bv !== e.byte_valid)
            begin
                $error("byte_valid mismatch: expected %0b, actual %0b", e.byte_valid, bv);
                errors++;
            end
            if (fd !== e.field_done)
            begin
                $error("field_done mismatch: expected %0b, actual %0b", e.field_done, fd);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

    endclass

endpackage

[bench/tb_top.sv]
// Testbench top for the record field deframer: directed and random byte streams in all modes.
module tb_top;

    import rfd_pkg::*;
    import rfd_check_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     data_byte  = '0;
    logic                  buffer_end = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  byte_valid;
    logic                  field_done;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    deframe_scoreboard     sb = new();

    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    items_sent     = 0;
    int                    cycle_count    = 0;
    int                    hold_left      = 0;
    bit                    hold_req       = 0;
    logic [BYTE_W-1:0]     cur_delim      = DELIM_RESET;

    record_field_deframer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .field_done (field_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Every result transfer is checked against the prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_byte, byte_valid, field_done);
    end

    // Offer one byte, with random idle cycles before it, and wait for its transfer.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        buffer_end <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(b, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic push_text(input string s, input bit last);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], last && (i == s.len() - 1));
    endtask

    // Wait until every owed result has come out and the pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One length-prefixed record: mostly well formed, some empty, saturated, cut or noisy.
    task automatic gen_length_record();
        int                r;
        int                n;
        int                cut;
        string             digits;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 72)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12);
            digits = $sformatf("%0d", n);
            if ($urandom_range(0, 9) == 0)
                digits = {"0", digits};
            // Occasional non-digit inside the prefix, which is skipped.
            if ($urandom_range(0, 9) == 0)
            begin
                do
                    b = BYTE_W'($urandom_range(0, 255));
                while (b == CHR_SPACE || (b >= CHR_ZERO && b <= CHR_NINE));
                push_byte(b, 1'b0);
            end
            push_text(digits, 1'b0);
            push_byte(CHR_SPACE, 1'b0);
            cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, n) : 0;
            for (int k = 1; k <= n; k++)
            begin
                push_byte(BYTE_W'($urandom_range(0, 255)),
                          (k == cut) || (k == n && $urandom_range(0, 2) == 0));
                if (k == cut)
                    break;
            end
        end
        else if (r < 82)
        begin
            case ($urandom_range(0, 2))
                0: push_text(" ", 1'b0);
                1: push_text("0 ", 1'b0);
                default: push_text("00 ", 1'b0);
            endcase
        end
        else if (r < 86)
        begin
            // Oversized prefix; the buffer end cuts the long payload short.
            push_text($sformatf("%0d ", $urandom_range(65536, 999999)), 1'b0);
            n = $urandom_range(1, 6);
            for (int k = 1; k <= n; k++)
                push_byte(BYTE_W'($urandom_range(0, 255)), k == n);
        end
        else if (r < 93)
        begin
            push_text($sformatf("%0d", $urandom_range(0, 99)), 1'b0);
            push_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int k = 1; k <= n; k++)
                push_byte(BYTE_W'($urandom_range(0, 255)), k == n);
        end
    endtask

    // One random phase at a given setting and idling pattern.
    task automatic run_phase(input logic [1:0] mode, input logic [COUNT_W-1:0] width,
                             input logic [BYTE_W-1:0] delim, input int send_pct,
                             input int recv_pct, input int count, input bit hold);
        int                target;
        logic [BYTE_W-1:0] b;
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_DELIM, CFG_DATA_W'(($urandom() & 16'hFF00) | delim));
        write_reg(CFG_MODE, CFG_DATA_W'(($urandom() & 16'hFFFC) | mode));
        cur_delim      = delim;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold)
        begin
            @(posedge clk);
            hold_req = 1;
            @(negedge clk);
        end
        target = items_sent + count;
        while (items_sent < target)
        begin
            case (mode)
                MODE_FIXED:
                begin
                    b = ($urandom_range(0, 4) == 0) ? CHR_NUL : BYTE_W'($urandom_range(0, 255));
                    push_byte(b, $urandom_range(0, 11) == 0);
                end
                MODE_DELIM:
                begin
                    b = ($urandom_range(0, 5) == 0) ? cur_delim : BYTE_W'($urandom_range(0, 255));
                    push_byte(b, $urandom_range(0, 19) == 0);
                end
                default: gen_length_record();
            endcase
        end
    endtask

    initial
    begin
        // Hold reset, then release it.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fixed width at its reset width of one: a full byte and a NUL.
        push_byte(8'hFF, 1'b0);
        push_byte(CHR_NUL, 1'b0);
        // Zero width acts as one; the widest field ends only at buffer end.
        write_reg(CFG_WIDTH, 16'h0000);
        push_byte(8'h41, 1'b0);
        write_reg(CFG_WIDTH, 16'hFFFF);
        push_byte(CHR_NUL, 1'b0);
        push_byte(8'h42, 1'b1);
        write_reg(CFG_SPARE, 16'hFFFF);

        // Delimited mode at both delimiter extremes.
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_DELIM));
        write_reg(CFG_DELIM, 16'h0000);
        push_byte(CHR_NUL, 1'b0);
        push_byte(8'hFF, 1'b1);
        write_reg(CFG_DELIM, 16'h00FF);
        push_byte(8'hFF, 1'b1);

        // Length mode: zero and empty prefixes, saturation, buffer end in the prefix
        // and on the space, and a mode write in the middle of a prefix.
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_LENGTH));
        push_text("0 ", 1'b0);
        push_text(" ", 1'b0);
        push_text("99999 ", 1'b0);
        push_byte(CHR_NUL, 1'b0);
        push_byte(CHR_SPACE, 1'b1);
        push_text("3", 1'b1);
        push_text("5 ", 1'b1);
        push_text("4", 1'b0);
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_LENGTH));
        push_text(" ", 1'b0);

        // The unused mode swallows bytes.
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_UNUSED));
        push_byte(8'h31, 1'b1);

        // Random phases over the three framing modes, settings and idling patterns.
        run_phase(MODE_FIXED,  16'd3,      8'd124, 0,  0,  127, 1'b1);
        run_phase(MODE_FIXED,  16'hFFFF,   8'd124, 82, 0,  127, 1'b0);
        run_phase(MODE_FIXED,  16'd1,      8'd124, 0,  82, 127, 1'b0);
        run_phase(MODE_FIXED,  16'd0,      8'd124, 35, 35, 127, 1'b0);
        run_phase(MODE_FIXED,  COUNT_W'($urandom_range(2, 40)), 8'd124, 0, 0, 127, 1'b0);
        run_phase(MODE_DELIM,  16'd1,      8'd124, 0,  0,  127, 1'b0);
        run_phase(MODE_DELIM,  16'd1,      8'h00,  82, 0,  127, 1'b0);
        run_phase(MODE_DELIM,  16'd1,      8'hFF,  0,  82, 127, 1'b0);
        run_phase(MODE_DELIM,  16'd1, BYTE_W'($urandom_range(0, 255)), 35, 35, 127, 1'b0);
        run_phase(MODE_LENGTH, 16'd1,      8'd124, 0,  0,  127, 1'b1);
        run_phase(MODE_LENGTH, 16'd1,      8'd124, 82, 0,  127, 1'b0);
        run_phase(MODE_LENGTH, 16'd1,      8'd124, 0,  82, 127, 1'b0);
        run_phase(MODE_LENGTH, 16'd1,      8'd124, 35, 35, 127, 1'b0);

        // Drain and report.
        settle();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
src/rfd_pkg.sv
src/rfd_in_reg.sv
src/rfd_core.sv
src/rfd_out_reg.sv
src/record_field_deframer.sv
bench/rfd_check_pkg.sv
bench/tb_top.sv
